// ----- hw/rtl/sync_length_checksum_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SLCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - package
// Types, register map and checksum helper shared by the deframer modules.
// ----------------------------------------------------------------------------
package slcd_pkg;

	// Frame kind codes as reported on the result channel
	typedef enum logic [2:0] {
		KIND_DATA = 3'd0,
		KIND_ACK  = 3'd1,
		KIND_NAK  = 3'd2,
		KIND_EST  = 3'd3,
		KIND_ESTA = 3'd4
	} kind_t;

	// Register map (index = paddr[4:2])
	localparam int          REG_IDX_W     = 3;
	localparam int          APB_ADDR_W    = 5;
	localparam logic [2:0]  REG_SYNC_1ST  = 3'd0;
	localparam logic [2:0]  REG_SYNC_2ND  = 3'd1;
	localparam logic [2:0]  REG_DATA_CODE = 3'd2;
	localparam logic [2:0]  REG_ACK_CODE  = 3'd3;
	localparam logic [2:0]  REG_NAK_CODE  = 3'd4;
	localparam logic [2:0]  REG_EST_CODE  = 3'd5;
	localparam logic [2:0]  REG_ESTA_CODE = 3'd6;

	// Reset values
	localparam logic [7:0]  RST_SYNC_1ST  = 8'hEB;
	localparam logic [7:0]  RST_SYNC_2ND  = 8'h90;
	localparam logic [5:0]  RST_DATA_CODE = 6'd2;
	localparam logic [5:0]  RST_ACK_CODE  = 6'd0;
	localparam logic [5:0]  RST_NAK_CODE  = 6'd1;
	localparam logic [5:0]  RST_EST_CODE  = 6'd63;
	localparam logic [5:0]  RST_ESTA_CODE = 6'd62;

	// Configuration as seen by the classifier
	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [5:0] data_code;
		logic [5:0] ack_code;
		logic [5:0] nak_code;
		logic [5:0] est_code;
		logic [5:0] esta_code;
	} cfg_t;

	// Classified byte passed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       sync1_hit;
		logic       sync2_hit;
		logic       kind_hit;
		kind_t      kind;
	} tok_t;

	// Rotate right by one, then add the byte (mod 256)
	function automatic logic [7:0] rot_add(input logic [7:0] sum, input logic [7:0] b);
		logic [7:0] r;
		r = {sum[0], sum[7:1]};
		return r + b;
	endfunction

endpackage

// ----- hw/rtl/slcd_if.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - channel interfaces
// Valid/ready byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface slcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
	logic       valid;
	logic       ready;
	logic       is_summary;
	logic [7:0] payload_byte;
	logic [2:0] frame_kind;
	logic [1:0] frame_id;
	logic [5:0] payload_length;
	logic       checksum_good;

	modport source (
		output valid, output is_summary, output payload_byte, output frame_kind,
		output frame_id, output payload_length, output checksum_good,
		input ready
	);
	modport sink (
		input valid, input is_summary, input payload_byte, input frame_kind,
		input frame_id, input payload_length, input checksum_good,
		output ready
	);
endinterface

// ----- hw/rtl/slcd_front.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - front end
// Accepts received bytes and classifies them against the sync bytes and
// the frame kind codes, pushing one token per byte into the queue.
// ----------------------------------------------------------------------------
module slcd_front (
	slcd_in_if.sink        in_ch,
	input  slcd_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           q_push,
	output slcd_pkg::tok_t q_tok
);
	import slcd_pkg::*;

	logic [5:0] code;

	// Handshake: take a byte whenever the queue has room
	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	// Sync compare and kind decode, priority data > ack > nak > est > esta
	assign code = in_ch.rx_byte[5:0];

	always_comb begin
		q_tok.data      = in_ch.rx_byte;
		q_tok.sync1_hit = (in_ch.rx_byte == cfg.sync_first);
		q_tok.sync2_hit = (in_ch.rx_byte == cfg.sync_second);
		q_tok.kind_hit  = 1'b1;
		q_tok.kind      = KIND_DATA;
		if (code == cfg.data_code) begin
			q_tok.kind = KIND_DATA;
		end else if (code == cfg.ack_code) begin
			q_tok.kind = KIND_ACK;
		end else if (code == cfg.nak_code) begin
			q_tok.kind = KIND_NAK;
		end else if (code == cfg.est_code) begin
			q_tok.kind = KIND_EST;
		end else if (code == cfg.esta_code) begin
			q_tok.kind = KIND_ESTA;
		end else begin
			q_tok.kind_hit = 1'b0;
		end
	end

endmodule

// ----- hw/rtl/slcd_fifo.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - token queue
// Two-entry queue decoupling the classifier from the frame parser.
// ----------------------------------------------------------------------------
module slcd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slcd_pkg::tok_t push_tok,
	output logic           full,
	input  logic           pop,
	output logic           tok_valid,
	output slcd_pkg::tok_t tok
);
	import slcd_pkg::*;

	tok_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign tok_valid = (count_q != 2'd0);
	assign tok       = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/slcd_back.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - back end
// Frame parser: walks sync, type, length, payload and checksum phases,
// keeps the rotate-add checksum and loads results into the output register.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_deframer_defines.svh"

module slcd_back #(
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  slcd_pkg::tok_t tok,
	output logic           tok_pop,
	slcd_out_if.source     out_ch
);
	import slcd_pkg::*;

	localparam int SAT   = MAX_FRAME_LEN - 2;
	localparam int LEN_W = $clog2(MAX_FRAME_LEN - 1);

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_TYPE  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5
	} phase_t;

	phase_t           phase_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       sum_q;
	logic [1:0]       id_q;
	kind_t            kind_q;

	logic             out_valid_q;
	logic             out_summary_q;
	logic [7:0]       out_byte_q;
	kind_t            out_kind_q;
	logic [1:0]       out_id_q;
	logic [5:0]       out_len_q;
	logic             out_good_q;

	logic [7:0]       sum_next;
	logic [LEN_W:0]   pos_inc;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W+5:0] len_ext;
	logic             emit;

	// Pop whenever the output register is free or is being emptied
	assign tok_pop = tok_valid && (!out_valid_q || out_ch.ready);

	// Datapath helpers
	always_comb begin
		sum_next = rot_add(sum_q, tok.data);
		pos_inc  = {1'b0, pos_q} + (LEN_W + 1)'(1);
		len_sat  = (tok.data >= 8'(SAT)) ? LEN_W'(SAT) : tok.data[LEN_W-1:0];
		len_ext  = (LEN_W + 6)'(len_q);
		emit     = tok_pop && ((phase_q == PH_DATA) || (phase_q == PH_SUM));
	end

	// Parser state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SYNC1;
			pos_q         <= '0;
			len_q         <= '0;
			sum_q         <= 8'd0;
			id_q          <= 2'd0;
			kind_q        <= KIND_DATA;
			out_valid_q   <= 1'b0;
			out_summary_q <= 1'b0;
			out_byte_q    <= 8'd0;
			out_kind_q    <= KIND_DATA;
			out_id_q      <= 2'd0;
			out_len_q     <= 6'd0;
			out_good_q    <= 1'b0;
		end else begin
			// drained result with no new one behind it
			if (out_valid_q && out_ch.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			if (tok_pop) begin
				unique case (phase_q)
					PH_SYNC1: begin
						if (tok.sync1_hit) begin
							phase_q <= PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						phase_q <= tok.sync2_hit ? PH_TYPE : PH_SYNC1;
					end
					PH_TYPE: begin
						// rotate of a zero sum is zero, so the sum starts at the byte
						id_q  <= tok.data[7:6];
						sum_q <= tok.data;
						pos_q <= '0;
						len_q <= '0;
						if (tok.kind_hit) begin
							kind_q  <= tok.kind;
							phase_q <= (tok.kind == KIND_DATA) ? PH_LEN : PH_SUM;
						end else begin
							phase_q <= PH_SYNC1;
						end
					end
					PH_LEN: begin
						sum_q   <= sum_next;
						len_q   <= len_sat;
						pos_q   <= '0;
						phase_q <= PH_DATA;
					end
					PH_DATA: begin
						// a zero-length frame still carries one byte, kept out of the sum
						if (pos_q < len_q) begin
							sum_q <= sum_next;
						end
						pos_q <= pos_inc[LEN_W-1:0];
						if (pos_inc >= {1'b0, len_q}) begin
							phase_q <= PH_SUM;
						end
						out_valid_q   <= 1'b1;
						out_summary_q <= 1'b0;
						out_byte_q    <= tok.data;
						out_kind_q    <= KIND_DATA;
						out_id_q      <= id_q;
						out_len_q     <= len_ext[5:0];
						out_good_q    <= 1'b0;
					end
					PH_SUM: begin
						out_valid_q   <= 1'b1;
						out_summary_q <= 1'b1;
						out_byte_q    <= 8'd0;
						out_kind_q    <= kind_q;
						out_id_q      <= id_q;
						if (kind_q == KIND_DATA) begin
							out_len_q  <= len_ext[5:0];
							out_good_q <= (tok.data == 8'd0) || (tok.data == sum_q);
						end else begin
							out_len_q  <= 6'd0;
							out_good_q <= 1'b1;
						end
						phase_q <= PH_SYNC1;
					end
					default: begin
						phase_q <= PH_SYNC1;
					end
				endcase
			end
		end
	end

	// Result channel
	assign out_ch.valid          = out_valid_q;
	assign out_ch.is_summary     = out_summary_q;
	assign out_ch.payload_byte   = out_byte_q;
	assign out_ch.frame_kind     = out_kind_q;
	assign out_ch.frame_id       = out_id_q;
	assign out_ch.payload_length = out_len_q;
	assign out_ch.checksum_good  = out_good_q;

	// Checks
	`SLCD_ASSERT_NEXT(a_sum_emits, clk, arst_n, tok_pop && (phase_q == PH_SUM), out_valid_q && out_summary_q, "checksum byte gave no summary")
	`SLCD_ASSERT_NEXT(a_data_emits, clk, arst_n, tok_pop && (phase_q == PH_DATA), out_valid_q && !out_summary_q, "payload byte gave no result")
	`SLCD_ASSERT_SAME(a_pos_bound, clk, arst_n, phase_q == PH_DATA, pos_q <= len_q, "payload position past frame length")
	`SLCD_ASSERT_SAME(a_payload_kind, clk, arst_n, out_valid_q && !out_summary_q, out_kind_q == KIND_DATA, "payload result outside a data frame")

endmodule

// ----- hw/rtl/sync_length_checksum_deframer.sv -----
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - top level
// Two-byte sync, length-framed byte deframer with rotate-add checksum and
// APB configuration registers.
//
//   channel | dir | payload                                   | handshake
//   in_ch   | in  | rx_byte                                   | valid/ready
//   out_ch  | out | is_summary, payload_byte, frame_kind,     | valid/ready
//           |     | frame_id, payload_length, checksum_good   |
//   apb     | in  | sync bytes and kind codes, 4-byte stride  | psel/penable
//
// One byte per cycle sustained while the result channel is not stalled; a taken
// byte is written into the token queue, then the parser pops it and loads its
// result into the output register.
// While a result stalls the two-entry token queue absorbs two more bytes, then
// input stalls; once the queue drains by one, input resumes the cycle after.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer #(
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [slcd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	slcd_in_if.sink                         in_ch,
	slcd_out_if.source                      out_ch
);
	import slcd_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	logic                 q_full;
	logic                 q_push;
	tok_t                 push_tok;
	logic                 q_pop;
	logic                 q_valid;
	tok_t                 q_tok;

	// Register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= RST_SYNC_1ST;
			cfg_q.sync_second <= RST_SYNC_2ND;
			cfg_q.data_code   <= RST_DATA_CODE;
			cfg_q.ack_code    <= RST_ACK_CODE;
			cfg_q.nak_code    <= RST_NAK_CODE;
			cfg_q.est_code    <= RST_EST_CODE;
			cfg_q.esta_code   <= RST_ESTA_CODE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_1ST:  cfg_q.sync_first  <= pwdata[7:0];
				REG_SYNC_2ND:  cfg_q.sync_second <= pwdata[7:0];
				REG_DATA_CODE: cfg_q.data_code   <= pwdata[5:0];
				REG_ACK_CODE:  cfg_q.ack_code    <= pwdata[5:0];
				REG_NAK_CODE:  cfg_q.nak_code    <= pwdata[5:0];
				REG_EST_CODE:  cfg_q.est_code    <= pwdata[5:0];
				REG_ESTA_CODE: cfg_q.esta_code   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_SYNC_1ST:  prdata = 32'(cfg_q.sync_first);
			REG_SYNC_2ND:  prdata = 32'(cfg_q.sync_second);
			REG_DATA_CODE: prdata = 32'(cfg_q.data_code);
			REG_ACK_CODE:  prdata = 32'(cfg_q.ack_code);
			REG_NAK_CODE:  prdata = 32'(cfg_q.nak_code);
			REG_EST_CODE:  prdata = 32'(cfg_q.est_code);
			REG_ESTA_CODE: prdata = 32'(cfg_q.esta_code);
			default:       prdata = 32'd0;
		endcase
	end

	// Classifier
	slcd_front u_front (
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_tok  (push_tok)
	);

	// Token queue
	slcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (q_pop),
		.tok_valid (q_valid),
		.tok       (q_tok)
	);

	// Frame parser
	slcd_back #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok       (q_tok),
		.tok_pop   (q_pop),
		.out_ch    (out_ch)
	);

endmodule

// ----- sim/tb_sync_length_checksum_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length/checksum deframer - testbench
// Feeds received bytes through the input channel and checks every payload and
// summary transaction against a local parser model. A short directed sequence
// is followed by random frames, noise and broken headers under five register
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_sync_length_checksum_deframer;
	import slcd_pkg::*;

	localparam int FRAME_MAX   = 64;
	localparam int SAT_LEN     = FRAME_MAX - 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIRECTED_N  = 29;
	localparam int BURST_BYTES = 85;

	// One result transaction as seen on the output channel
	typedef struct packed {
		logic       is_summary;
		logic [7:0] payload_byte;
		kind_t      frame_kind;
		logic [1:0] frame_id;
		logic [5:0] payload_length;
		logic       checksum_good;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t want;
	} directed_row_t;

	typedef enum logic [2:0] {
		HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, TAKE_LEN, TAKE_DATA, TAKE_CHECK
	} parse_state_t;

	localparam frame_result_t NO_RESULT = '0;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	slcd_in_if  in_bus ();
	slcd_out_if out_bus ();

	sync_length_checksum_deframer #(
		.MAX_FRAME_LEN(FRAME_MAX)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_bus),
		.out_ch  (out_bus)
	);

	// Parser model state and its copy of the registers
	cfg_t         cfg;
	parse_state_t pstate;
	logic [7:0]   hdr_type;
	logic [7:0]   run_sum;
	logic [6:0]   data_pos;
	logic [5:0]   data_len;
	kind_t        cur_kind;

	frame_result_t frame_results_due [$];
	directed_row_t directed_rows [DIRECTED_N];

	bit steady;
	bit held_off;
	int cycles;
	int mismatch_count;
	int results_seen;
	int payloads_checked;
	int summaries_checked;
	int bad_sums_seen;
	int bytes_sent;
	int frame_bytes;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, frame_results_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Rotate right by one, then add (mod 256)
	function automatic logic [7:0] checksum_step(input logic [7:0] acc, input logic [7:0] b);
		logic [15:0] twice;
		twice = {acc, acc} >> 1;
		return twice[7:0] + b;
	endfunction

	// Advance the parser model by one byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
		logic [5:0] code;
		r = NO_RESULT;
		code = b[5:0];
		case (pstate)
			HUNT_FIRST: begin
				if (b == cfg.sync_first)
					pstate = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				pstate = (b == cfg.sync_second) ? TAKE_TYPE : HUNT_FIRST;
			end
			TAKE_TYPE: begin
				hdr_type = b;
				run_sum = checksum_step(8'd0, b);
				data_pos = 7'd0;
				data_len = 6'd0;
				pstate = TAKE_CHECK;
				// priority follows register order
				if (code == cfg.data_code) begin
					cur_kind = KIND_DATA;
					pstate = TAKE_LEN;
				end else if (code == cfg.ack_code) begin
					cur_kind = KIND_ACK;
				end else if (code == cfg.nak_code) begin
					cur_kind = KIND_NAK;
				end else if (code == cfg.est_code) begin
					cur_kind = KIND_EST;
				end else if (code == cfg.esta_code) begin
					cur_kind = KIND_ESTA;
				end else begin
					pstate = HUNT_FIRST;
				end
			end
			TAKE_LEN: begin
				run_sum = checksum_step(run_sum, b);
				data_len = (b >= 8'(SAT_LEN)) ? 6'(SAT_LEN) : b[5:0];
				data_pos = 7'd0;
				pstate = TAKE_DATA;
			end
			TAKE_DATA: begin
				// a zero-length frame still carries one byte, left out of the sum
				if (data_pos < {1'b0, data_len})
					run_sum = checksum_step(run_sum, b);
				data_pos = data_pos + 7'd1;
				if (data_pos >= {1'b0, data_len})
					pstate = TAKE_CHECK;
				r.is_summary = 1'b0;
				r.payload_byte = b;
				r.frame_kind = KIND_DATA;
				r.frame_id = hdr_type[7:6];
				r.payload_length = data_len;
				r.checksum_good = 1'b0;
				return 1'b1;
			end
			TAKE_CHECK: begin
				r.is_summary = 1'b1;
				r.frame_kind = cur_kind;
				r.frame_id = hdr_type[7:6];
				r.checksum_good = 1'b1;
				if (cur_kind == KIND_DATA) begin
					r.payload_length = data_len;
					r.checksum_good = (b == 8'd0) || (b == run_sum);
				end
				pstate = HUNT_FIRST;
				return 1'b1;
			end
			default: begin
				pstate = HUNT_FIRST;
			end
		endcase
		return 1'b0;
	endfunction

	// Offer one byte with random gaps; predict once it is taken
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
		input frame_result_t want = NO_RESULT);
		frame_result_t r;
		while (!steady && $urandom_range(99) < 34) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.rx_byte <= b;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		bytes_sent++;
		if (deframe_byte(b, r))
			frame_results_due.push_back(typed ? want : r);
	endtask

	// APB write: setup then access; psel is left high for back-to-back writes
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_SYNC_1ST:  cfg.sync_first = val;
			REG_SYNC_2ND:  cfg.sync_second = val;
			REG_DATA_CODE: cfg.data_code = val[5:0];
			REG_ACK_CODE:  cfg.ack_code = val[5:0];
			REG_NAK_CODE:  cfg.nak_code = val[5:0];
			REG_EST_CODE:  cfg.est_code = val[5:0];
			REG_ESTA_CODE: cfg.esta_code = val[5:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [7:0] s1, input logic [7:0] s2,
		input logic [5:0] dc, input logic [5:0] ac, input logic [5:0] nc,
		input logic [5:0] ec, input logic [5:0] eac);
		write_reg(REG_SYNC_1ST, s1);
		write_reg(REG_SYNC_2ND, s2);
		write_reg(REG_DATA_CODE, {2'b00, dc});
		write_reg(REG_ACK_CODE, {2'b00, ac});
		write_reg(REG_NAK_CODE, {2'b00, nc});
		write_reg(REG_EST_CODE, {2'b00, ec});
		write_reg(REG_ESTA_CODE, {2'b00, eac});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop offering, let every result drain, then allow for bytes with no result
	task automatic settle();
		in_bus.valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One random frame, or noise / a broken header now and then
	task automatic send_frame();
		int         pick;
		int         n_bytes;
		int         sat;
		int         i;
		logic [5:0] code;
		logic [7:0] hdr;
		logic [7:0] len_raw;
		logic [7:0] sum;
		logic [7:0] pb;
		logic [7:0] csum;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
			return;
		end
		if (pick < 13) begin
			// wrong second sync byte
			send_byte(cfg.sync_first);
			pb = 8'($urandom_range(255));
			if (pb == cfg.sync_second)
				pb = ~pb;
			send_byte(pb);
			return;
		end
		if (pick < 18) begin
			// header cut short, next frame lands in its type slot
			send_byte(cfg.sync_first);
			send_byte(cfg.sync_second);
			return;
		end

		pick = $urandom_range(99);
		if (pick < 55)
			code = cfg.data_code;
		else if (pick < 65)
			code = cfg.ack_code;
		else if (pick < 73)
			code = cfg.nak_code;
		else if (pick < 81)
			code = cfg.est_code;
		else if (pick < 90)
			code = cfg.esta_code;
		else
			code = 6'($urandom_range(63));
		hdr = {2'($urandom_range(3)), code};
		send_byte(cfg.sync_first);
		send_byte(cfg.sync_second);
		send_byte(hdr);
		frame_bytes += 3;
		sum = checksum_step(8'd0, hdr);

		if (code == cfg.data_code) begin
			pick = $urandom_range(99);
			if (pick < 90)
				len_raw = 8'($urandom_range(8));
			else if (pick < 95)
				len_raw = 8'($urandom_range(61, 9));
			else
				len_raw = 8'($urandom_range(255, 62));
			send_byte(len_raw);
			sum = checksum_step(sum, len_raw);
			sat = (len_raw >= 8'(SAT_LEN)) ? SAT_LEN : int'(len_raw);
			n_bytes = (sat == 0) ? 1 : sat;
			for (i = 0; i < n_bytes; i++) begin
				pb = 8'($urandom_range(255));
				if (i < sat)
					sum = checksum_step(sum, pb);
				send_byte(pb);
			end
			frame_bytes += n_bytes + 1;
		end else if (!(code == cfg.ack_code || code == cfg.nak_code ||
			code == cfg.est_code || code == cfg.esta_code)) begin
			// unknown kind: frame dropped
			return;
		end

		pick = $urandom_range(99);
		if (pick < 55)
			csum = sum;
		else if (pick < 70)
			csum = 8'd0;
		else
			csum = 8'($urandom_range(255));
		send_byte(csum);
		frame_bytes++;
	endtask

	// Random frames until enough frame bytes went in, then back to hunting
	task automatic random_burst();
		frame_bytes = 0;
		while (frame_bytes < BURST_BYTES)
			send_frame();
		while (pstate != HUNT_FIRST)
			send_byte(8'($urandom_range(255)));
	endtask

	// Output side: random back-pressure plus one long hold-off
	initial begin : result_sink
		int hold;
		out_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 40) begin
				held_off = 1'b1;
				out_bus.ready <= 1'b0;
				for (hold = 0; hold < 200; hold++)
					@(posedge clk);
			end else begin
				out_bus.ready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	// Compare each result transaction with the oldest one due
	always @(posedge clk) begin : result_check
		frame_result_t got;
		frame_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			got.is_summary = out_bus.is_summary;
			got.payload_byte = out_bus.payload_byte;
			got.frame_kind = kind_t'(out_bus.frame_kind);
			got.frame_id = out_bus.frame_id;
			got.payload_length = out_bus.payload_length;
			got.checksum_good = out_bus.checksum_good;
			results_seen++;
			if (frame_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("[%0t] result with none due: sum=%0b byte=%02h kind=%0d",
						$realtime, got.is_summary, got.payload_byte, got.frame_kind);
			end else begin
				want = frame_results_due.pop_front();
				if (got.is_summary !== want.is_summary ||
					got.payload_byte !== want.payload_byte ||
					got.frame_kind !== want.frame_kind ||
					got.frame_id !== want.frame_id ||
					got.payload_length !== want.payload_length ||
					got.checksum_good !== want.checksum_good) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] mismatch got:  sum=%0b byte=%02h kind=%0d id=%0d len=%0d good=%0b",
							$realtime, got.is_summary, got.payload_byte, got.frame_kind,
							got.frame_id, got.payload_length, got.checksum_good);
						$display("               want: sum=%0b byte=%02h kind=%0d id=%0d len=%0d good=%0b",
							want.is_summary, want.payload_byte, want.frame_kind,
							want.frame_id, want.payload_length, want.checksum_good);
					end
				end
				if (want.is_summary) begin
					summaries_checked++;
					if (!want.checksum_good)
						bad_sums_seen++;
				end else begin
					payloads_checked++;
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int i;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_bus.valid <= 1'b0;
		in_bus.rx_byte <= 8'd0;

		cfg.sync_first = RST_SYNC_1ST;
		cfg.sync_second = RST_SYNC_2ND;
		cfg.data_code = RST_DATA_CODE;
		cfg.ack_code = RST_ACK_CODE;
		cfg.nak_code = RST_NAK_CODE;
		cfg.est_code = RST_EST_CODE;
		cfg.esta_code = RST_ESTA_CODE;
		pstate = HUNT_FIRST;
		hdr_type = 8'd0;
		run_sum = 8'd0;
		data_pos = 7'd0;
		data_len = 6'd0;
		cur_kind = KIND_DATA;

		// Directed bytes under reset settings; short frames report good
		directed_rows = '{
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'hC0, 1'b0, NO_RESULT},
			'{8'h55, 1'b1, '{1'b1, 8'h00, KIND_ACK, 2'd3, 6'd0, 1'b1}},
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'h01, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, '{1'b1, 8'h00, KIND_NAK, 2'd0, 6'd0, 1'b1}},
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'h7F, 1'b0, NO_RESULT},
			'{8'hFF, 1'b1, '{1'b1, 8'h00, KIND_EST, 2'd1, 6'd0, 1'b1}},
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'hBE, 1'b0, NO_RESULT},
			'{8'h12, 1'b1, '{1'b1, 8'h00, KIND_ESTA, 2'd2, 6'd0, 1'b1}},
			// zero length: one byte still carried, zero checksum passes
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'h02, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
			'{8'hFF, 1'b1, '{1'b0, 8'hFF, KIND_DATA, 2'd0, 6'd0, 1'b0}},
			'{8'h00, 1'b1, '{1'b1, 8'h00, KIND_DATA, 2'd0, 6'd0, 1'b1}},
			// bad second sync byte is not taken as a new first sync byte
			'{8'hEB, 1'b0, NO_RESULT}, '{8'hEB, 1'b0, NO_RESULT},
			'{8'h90, 1'b0, NO_RESULT}, '{8'hC0, 1'b0, NO_RESULT},
			// unknown kind is dropped silently
			'{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
			'{8'h3D, 1'b0, NO_RESULT}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_N; i++)
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
		random_burst();
		settle();

		// Extreme sync bytes; nak shares the data code, esta shares the ack code
		apply_setting(8'h00, 8'hFF, 6'd63, 6'd0, 6'd63, 6'd1, 6'd0);
		random_burst();
		settle();

		// Reversed extremes, both channels running flat out
		steady = 1'b1;
		apply_setting(8'hFF, 8'h00, 6'd0, 6'd0, 6'd5, 6'd63, 6'd62);
		random_burst();
		settle();
		steady = 1'b0;

		// Random settings
		apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
			6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)),
			6'($urandom_range(63)), 6'($urandom_range(63)));
		random_burst();
		settle();

		// Both sync bytes equal
		pwdata <= '0;
		i = $urandom_range(255);
		apply_setting(8'(i), 8'(i), 6'($urandom_range(63)), 6'($urandom_range(63)),
			6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
		random_burst();
		settle();

		$display("Sent %0d bytes over five register settings; checked %0d payload and %0d summary transactions",
			bytes_sent, payloads_checked, summaries_checked);
		$display("%0d summaries flagged a bad checksum; long output hold-off applied: %0d",
			bad_sums_seen, held_off);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
